### rtl/ffha_pkg.sv
// shared types and constants of the first-fit heap allocator
// no dependencies
package ffha_pkg;

	localparam int FIELD_W          = 13;
	localparam int ARENA_BYTES_DEF  = 4096;
	localparam int HEADER_BYTES_DEF = 16;
	localparam int ARENA_RESET      = 4096;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_NOFIT   = 2'd1,
		STAT_IGNORED = 2'd2
	} status_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_A_RD,
		S_A_CHK,
		S_A_NXT,
		S_A_SPL,
		S_A_SN,
		S_A_WH,
		S_LK_A,
		S_LK_W,
		S_F_CHK,
		S_F_RH,
		S_F_NX,
		S_F_RN,
		S_F_WH,
		S_F_RP,
		S_F_KH,
		S_DONE
	} state_t;

endpackage

### rtl/ffha_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/ffha_alu.sv
// shared three-operand adder/subtractor with borrow flag
// depends on ffha_pkg
module ffha_alu import ffha_pkg::*; #(
	parameter int W = 14
) (
	input  alu_op_t      op,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  logic [W-1:0] c,
	output logic [W-1:0] sum,
	output logic         neg
);

	logic [W+1:0] ext;

	always_comb begin
		case (op)
			ALU_ADD: ext = {2'b00, a} + {2'b00, b} + {2'b00, c};
			ALU_SUB: ext = {2'b00, a} - {2'b00, b} - {2'b00, c};
			default: ext = '0;
		endcase
	end

	assign sum = ext[W-1:0];
	assign neg = ext[W+1];

endmodule

### rtl/first_fit_heap_allocator.sv
// first-fit heap allocator top level: sequencer, header ram and shared adder
// depends on ffha_pkg, ffha_ram, ffha_alu
//
//  channel  direction  handshake              payload
//  cfg      in         cfg_valid / cfg_ready  arena_size
//  in       in         in_valid / in_stall    mode, request_size, address
//  out      out        out_valid / out_stall  status, granted_address, bytes_in_use
//
// one header read per block visited: an allocate walks the blocks (read, check, step to next)
// then splits and does bookkeeping; a free checks the header and merges with free neighbours
// after reset and after each arena_size write of at least HEADER_BYTES a clearing pass
// sweeps all ARENA_BYTES entries of the header ram, one entry a cycle, with in_stall high
// the result sits in an output register; the sequencer waits in its last step while
// out_stall holds a previous result
module first_fit_heap_allocator import ffha_pkg::*; #(
	parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [FIELD_W-1:0] arena_size,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [FIELD_W-1:0] request_size,
	input  logic [FIELD_W-1:0] address,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic [FIELD_W-1:0] granted_address,
	output logic [FIELD_W-1:0] bytes_in_use
);

	localparam int AW = $clog2(ARENA_BYTES);
	localparam int OW = AW + 1;
	localparam int XW = ((FIELD_W > OW) ? FIELD_W : OW) + 1;
	localparam int WW = 2 + 2 * AW;
	localparam int ARENA_INIT = (ARENA_RESET < ARENA_BYTES) ? ARENA_RESET : ARENA_BYTES;
	localparam logic [AW-1:0] CLR_LAST = AW'(ARENA_BYTES - 1);
	localparam logic [XW-1:0] HX = XW'(HEADER_BYTES);

	state_t state_q, nxt_state, ret_q;
	logic [AW-1:0] clr_q, n_q, len_q, bef_q, lk_base_q, lk_len_q;
	logic [OW-1:0] arena_q, used_q, h_q;
	logic mode_q;
	logic [FIELD_W-1:0] size_q, addr_q;
	status_t stat_q, status_q;
	logic out_valid_q;
	logic [FIELD_W-1:0] granted_q, biu_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [WW-1:0] ram_wdata, ram_rdata;
	logic rd_hv, rd_used;
	logic [AW-1:0] rd_len, rd_bef;

	alu_op_t alu_op;
	logic [XW-1:0] alu_a, alu_b, alu_c, alu_sum;
	logic alu_neg;

	logic cfg_legal, in_acc, out_free, sum_in_arena;
	logic [OW-1:0] cfg_val;

	assign cfg_ready = 1'b1;
	assign cfg_legal = cfg_valid && (arena_size >= FIELD_W'(HEADER_BYTES));
	assign cfg_val = (XW'(arena_size) > XW'(ARENA_BYTES)) ? OW'(ARENA_BYTES) : OW'(arena_size);
	// a legal arena write restarts the sequencer, so no beat is taken beside any arena write
	assign in_stall = (state_q != S_IDLE) || cfg_valid;
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign sum_in_arena = (alu_sum < XW'(arena_q));

	assign rd_hv   = ram_rdata[WW-1];
	assign rd_used = ram_rdata[WW-2];
	assign rd_len  = ram_rdata[2*AW-1:AW];
	assign rd_bef  = ram_rdata[AW-1:0];

	ffha_ram #(
		.WIDTH(WW),
		.DEPTH(ARENA_BYTES)
	) u_hdr_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ffha_alu #(
		.W(XW)
	) u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.c  (alu_c),
		.sum(alu_sum),
		.neg(alu_neg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= nxt_state;
		end
	end

	always_comb begin
		nxt_state = state_q;
		ram_we    = 1'b0;
		ram_waddr = h_q[AW-1:0];
		ram_wdata = '0;
		ram_raddr = h_q[AW-1:0];
		alu_op    = ALU_ADD;
		alu_a     = '0;
		alu_b     = '0;
		alu_c     = '0;
		case (state_q)
			S_CLR: begin
				// entry zero gets the single free block, the rest lose their header mark
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				alu_op    = ALU_SUB;
				alu_a     = XW'(arena_q);
				alu_b     = HX;
				if (clr_q == '0) begin
					ram_wdata = {1'b1, 1'b0, alu_sum[AW-1:0], {AW{1'b0}}};
				end
				if (clr_q == CLR_LAST) begin
					nxt_state = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					nxt_state = mode ? S_F_CHK : S_A_RD;
				end
			end
			S_A_RD: begin
				if (XW'(h_q) >= XW'(arena_q)) begin
					nxt_state = S_DONE;
				end else begin
					nxt_state = S_A_CHK;
				end
			end
			S_A_CHK: begin
				alu_op = ALU_SUB;
				alu_a  = XW'(rd_len);
				alu_b  = XW'(size_q);
				if (!rd_used && !alu_neg) begin
					nxt_state = S_A_SPL;
				end else begin
					nxt_state = S_A_NXT;
				end
			end
			S_A_NXT: begin
				alu_a     = XW'(h_q);
				alu_b     = HX;
				alu_c     = XW'(len_q);
				nxt_state = S_A_RD;
			end
			S_A_SPL: begin
				// split only when the leftover exceeds one header
				alu_op = ALU_SUB;
				alu_a  = XW'(len_q);
				alu_b  = XW'(size_q);
				alu_c  = HX;
				if (!alu_neg && alu_sum != '0) begin
					nxt_state = S_A_SN;
				end else begin
					nxt_state = S_A_WH;
				end
			end
			S_A_SN: begin
				alu_a     = XW'(h_q);
				alu_b     = HX;
				alu_c     = XW'(size_q);
				ram_we    = 1'b1;
				ram_waddr = alu_sum[AW-1:0];
				ram_wdata = {1'b1, 1'b0, lk_len_q, h_q[AW-1:0]};
				nxt_state = S_LK_A;
			end
			S_A_WH: begin
				ram_we    = 1'b1;
				ram_wdata = {1'b1, 1'b1, len_q, bef_q};
				alu_a     = XW'(used_q);
				alu_b     = HX;
				alu_c     = XW'(len_q);
				nxt_state = S_DONE;
			end
			S_LK_A: begin
				alu_a = XW'(lk_base_q);
				alu_b = HX;
				alu_c = XW'(lk_len_q);
				if (sum_in_arena) begin
					ram_raddr = alu_sum[AW-1:0];
					nxt_state = S_LK_W;
				end else begin
					nxt_state = ret_q;
				end
			end
			S_LK_W: begin
				ram_we    = 1'b1;
				ram_waddr = n_q;
				ram_wdata = {rd_hv, rd_used, rd_len, lk_base_q};
				nxt_state = ret_q;
			end
			S_F_CHK: begin
				alu_op = ALU_SUB;
				alu_a  = XW'(addr_q);
				alu_b  = HX;
				if (alu_neg || !sum_in_arena) begin
					nxt_state = S_DONE;
				end else begin
					ram_raddr = alu_sum[AW-1:0];
					nxt_state = S_F_RH;
				end
			end
			S_F_RH: begin
				alu_op = ALU_SUB;
				alu_a  = XW'(used_q);
				alu_b  = HX;
				alu_c  = XW'(rd_len);
				if (!rd_hv || !rd_used) begin
					nxt_state = S_DONE;
				end else begin
					nxt_state = S_F_NX;
				end
			end
			S_F_NX: begin
				alu_a = XW'(h_q);
				alu_b = HX;
				alu_c = XW'(len_q);
				if (sum_in_arena) begin
					ram_raddr = alu_sum[AW-1:0];
					nxt_state = S_F_RN;
				end else begin
					nxt_state = S_F_WH;
				end
			end
			S_F_RN: begin
				// absorb a free next block
				alu_a = XW'(len_q);
				alu_b = HX;
				alu_c = XW'(rd_len);
				if (!rd_used) begin
					ram_we    = 1'b1;
					ram_waddr = n_q;
					ram_wdata = {1'b0, rd_used, rd_len, rd_bef};
					nxt_state = S_LK_A;
				end else begin
					nxt_state = S_F_WH;
				end
			end
			S_F_WH: begin
				ram_we    = 1'b1;
				ram_wdata = {1'b1, 1'b0, len_q, bef_q};
				if (h_q != '0) begin
					ram_raddr = bef_q;
					nxt_state = S_F_RP;
				end else begin
					nxt_state = S_DONE;
				end
			end
			S_F_RP: begin
				// fold into a free previous block
				alu_a = XW'(rd_len);
				alu_b = HX;
				alu_c = XW'(len_q);
				if ((XW'(bef_q) < XW'(arena_q)) && !rd_used) begin
					ram_we    = 1'b1;
					ram_waddr = bef_q;
					ram_wdata = {rd_hv, 1'b0, alu_sum[AW-1:0], rd_bef};
					nxt_state = S_F_KH;
				end else begin
					nxt_state = S_DONE;
				end
			end
			S_F_KH: begin
				ram_we    = 1'b1;
				ram_wdata = {1'b0, 1'b0, len_q, bef_q};
				nxt_state = S_LK_A;
			end
			S_DONE: begin
				alu_a = XW'(h_q);
				alu_b = HX;
				if (out_free) begin
					nxt_state = S_IDLE;
				end
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase
		if (cfg_legal) begin
			nxt_state = S_CLR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q     <= OW'(ARENA_INIT);
			used_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_legal) begin
				arena_q <= cfg_val;
				used_q  <= '0;
				clr_q   <= '0;
			end else begin
				if (state_q == S_CLR) begin
					clr_q <= clr_q + 1'b1;
				end
				if (state_q == S_A_WH || (state_q == S_F_RH && rd_hv && rd_used)) begin
					used_q <= alu_sum[OW-1:0];
				end
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					mode_q <= mode;
					size_q <= request_size;
					addr_q <= address;
					h_q    <= '0;
					stat_q <= STAT_DONE;
				end
			end
			S_A_RD: begin
				if (XW'(h_q) >= XW'(arena_q)) begin
					stat_q <= STAT_NOFIT;
				end
			end
			S_A_CHK: begin
				len_q <= rd_len;
				bef_q <= rd_bef;
			end
			S_A_NXT: h_q <= alu_sum[OW-1:0];
			S_A_SPL: lk_len_q <= alu_sum[AW-1:0];
			S_A_SN: begin
				lk_base_q <= alu_sum[AW-1:0];
				len_q     <= AW'(size_q);
				ret_q     <= S_A_WH;
			end
			S_LK_A: n_q <= alu_sum[AW-1:0];
			S_F_CHK: begin
				h_q <= alu_sum[OW-1:0];
				if (alu_neg || !sum_in_arena) begin
					stat_q <= STAT_IGNORED;
				end
			end
			S_F_RH: begin
				len_q <= rd_len;
				bef_q <= rd_bef;
				if (!rd_hv || !rd_used) begin
					stat_q <= STAT_IGNORED;
				end
			end
			S_F_NX: n_q <= alu_sum[AW-1:0];
			S_F_RN: begin
				if (!rd_used) begin
					len_q     <= alu_sum[AW-1:0];
					lk_base_q <= h_q[AW-1:0];
					lk_len_q  <= alu_sum[AW-1:0];
					ret_q     <= S_F_WH;
				end
			end
			S_F_RP: begin
				lk_base_q <= bef_q;
				lk_len_q  <= alu_sum[AW-1:0];
				ret_q     <= S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					status_q  <= stat_q;
					granted_q <= (!mode_q && stat_q == STAT_DONE) ? FIELD_W'(alu_sum) : '0;
					biu_q     <= FIELD_W'(used_q);
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_address = granted_q;
	assign bytes_in_use    = biu_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= arena_q)
		else $error("bytes in use exceeds arena");

	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_DONE |-> granted_address == '0)
		else $error("address granted on a failed request");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q != S_IDLE)
		else $error("sequencer idle right after an accepted beat");

	a_cfg_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_legal |=> used_q == '0 && state_q == S_CLR)
		else $error("arena write did not restart the arena");

	a_walk_in_arena: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_A_CHK |-> h_q < arena_q)
		else $error("block walk left the arena");

endmodule
